// File: sv/bdq_pkg.sv
// Shared types and constants for the bounded deque with search and delete.
package bdq_pkg;

    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_SEARCH    = 3'd4,
        OP_DELETE    = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

// File: sv/bdq_req_if.sv
// Request channel: opcode and value with valid/ready handshake.
interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [bdq_pkg::OPCODE_W-1:0] opcode;
    logic signed [bdq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// File: sv/bdq_rsp_if.sv
// Response channel: result fields with valid/ready handshake.
interface bdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bdq_pkg::DATA_W-1:0]   result_value;
    logic                                found;
    logic        [bdq_pkg::POS_W-1:0]    position;
    logic        [bdq_pkg::STATUS_W-1:0] status;
    logic        [bdq_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output result_value, output found, output position,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input result_value, input found, input position,
                    input status, input entry_count, output ready);
endinterface

// File: sv/bdq_ram.sv
// Ring storage: one write port, one read port with registered read data.
module bdq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/bounded_deque_with_search_delete.sv
// Flow after accept: insert passes exec and done; remove adds a read-wait (not when empty);
// search and delete walk from the head, one stored entry per cycle on the RAM port.
// Throughput: one request at a time; req.ready is high only while idle, and a finished
// result may wait in the output register while the next request is taken.
// Reset (rst_n low, asynchronous) empties the list and zeroes the head; the store itself
// is not cleared, since entries are only read after they are written.
module bounded_deque_with_search_delete #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    bdq_req_if.sink         req,
    bdq_rsp_if.source       rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    bdq_pkg::state_t         state_reg, state_next;
    bdq_pkg::op_t            op_reg, op_next;
    bdq_pkg::status_t        status_reg, status_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [IDX_W-1:0]        scan_slot_reg, scan_slot_next;
    logic [IDX_W-1:0]        wr_slot_reg, wr_slot_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [bdq_pkg::DATA_W-1:0] rv_reg, rv_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic [bdq_pkg::DATA_W-1:0]  rsp_value_reg;
    logic                        rsp_found_reg;
    logic [bdq_pkg::POS_W-1:0]   rsp_pos_reg;
    logic [bdq_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [bdq_pkg::COUNT_W-1:0] rsp_count_reg;
    logic                        rsp_load;

    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_addr;
    logic [VALUE_BITS-1:0]   mem_wr_data;
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic [VALUE_BITS-1:0]   mem_rd_data;

    logic signed [VALUE_BITS+31:0] in_ext;
    logic signed [VALUE_BITS-1:0]  rd_s;
    logic signed [VALUE_BITS+31:0] rd_ext;
    logic [CNT_W-1:0]        tail_off;
    logic [CNT_W:0]          tail_sum;
    logic [IDX_W-1:0]        tail_slot;
    logic [IDX_W-1:0]        head_inc;
    logic [IDX_W-1:0]        head_dec;
    logic [IDX_W-1:0]        ptr_inc;
    logic                    is_full;
    logic                    is_empty;
    logic                    is_match;
    logic                    last_cmp;
    logic                    more_shift;
    logic [IDX_W+5:0]        pos_wide;
    logic [CNT_W+6:0]        count_wide;

    bdq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Store width: sign-extend the request value, then keep VALUE_BITS.
    assign in_ext = (VALUE_BITS + 32)'(req.value);
    assign rd_s   = mem_rd_data;
    assign rd_ext = (VALUE_BITS + 32)'(rd_s);

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign is_match = (mem_rd_data == val_reg);

    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);
    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign ptr_inc  = (ptr_reg == IDX_W'(CAPACITY - 1)) ? '0 : ptr_reg + IDX_W'(1);

    // Slot of the back end: count for insert, count - 1 for remove.
    assign tail_off  = (op_reg == bdq_pkg::OP_INS_BACK) ? count_reg : count_reg - CNT_W'(1);
    assign tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(tail_off);
    assign tail_slot = (tail_sum >= (CNT_W + 1)'(CAPACITY))
                       ? IDX_W'(tail_sum - (CNT_W + 1)'(CAPACITY))
                       : IDX_W'(tail_sum);

    assign last_cmp   = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(count_reg);
    assign more_shift = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(count_reg);

    assign req.ready = (state_reg == bdq_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        val_next       = val_reg;
        ptr_next       = ptr_reg;
        scan_slot_next = scan_slot_reg;
        wr_slot_next   = wr_slot_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        rv_next        = rv_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_load       = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = tail_slot;
        mem_wr_data    = val_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = ptr_reg;

        unique case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = bdq_pkg::op_t'(req.opcode);
                    val_next    = in_ext[VALUE_BITS-1:0];
                    status_next = bdq_pkg::ST_OK;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    rv_next     = '0;
                    state_next  = bdq_pkg::S_EXEC;
                end
            end

            bdq_pkg::S_EXEC:
            begin
                state_next = bdq_pkg::S_DONE;
                unique case (op_reg)
                    bdq_pkg::OP_INS_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = head_dec;
                            head_next   = head_dec;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    bdq_pkg::OP_INS_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    bdq_pkg::OP_REM_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_reg;
                            head_next   = head_inc;
                            count_next  = count_reg - CNT_W'(1);
                            state_next  = bdq_pkg::S_RDWAIT;
                        end
                    end
                    bdq_pkg::OP_REM_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = tail_slot;
                            count_next  = count_reg - CNT_W'(1);
                            state_next  = bdq_pkg::S_RDWAIT;
                        end
                    end
                    bdq_pkg::OP_SEARCH,
                    bdq_pkg::OP_DELETE:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdq_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            // Start the walk at the head; the compare uses the registered read data in the next cycle.
                            mem_rd_en      = 1'b1;
                            mem_rd_addr    = head_reg;
                            scan_slot_next = head_reg;
                            ptr_next       = head_inc;
                            idx_next       = '0;
                            state_next     = bdq_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = bdq_pkg::S_DONE;
                    end
                endcase
            end

            bdq_pkg::S_RDWAIT:
            begin
                rv_next    = rd_ext[bdq_pkg::DATA_W-1:0];
                state_next = bdq_pkg::S_DONE;
            end

            bdq_pkg::S_SCAN:
            begin
                priority if (is_match)
                begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    if (op_reg == bdq_pkg::OP_DELETE && !last_cmp)
                    begin
                        // Pull the next entry down into the matched slot.
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = ptr_reg;
                        scan_slot_next = ptr_reg;
                        ptr_next       = ptr_inc;
                        wr_slot_next   = scan_slot_reg;
                        state_next     = bdq_pkg::S_SHIFT;
                    end
                    else
                    begin
                        if (op_reg == bdq_pkg::OP_DELETE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = bdq_pkg::S_DONE;
                    end
                end
                else if (last_cmp)
                begin
                    status_next = bdq_pkg::ST_NOT_FOUND;
                    state_next  = bdq_pkg::S_DONE;
                end
                else
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = ptr_reg;
                    scan_slot_next = ptr_reg;
                    ptr_next       = ptr_inc;
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end

            bdq_pkg::S_SHIFT:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = wr_slot_reg;
                mem_wr_data  = mem_rd_data;
                wr_slot_next = scan_slot_reg;
                idx_next     = idx_reg + IDX_W'(1);
                if (more_shift)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = ptr_reg;
                    scan_slot_next = ptr_reg;
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = bdq_pkg::S_DONE;
                end
            end

            bdq_pkg::S_DONE:
            begin
                // Hold until the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = bdq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        scan_slot_reg <= scan_slot_next;
        wr_slot_reg   <= wr_slot_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        rv_reg        <= rv_next;
    end

    assign pos_wide   = (IDX_W + 6)'(pos_reg);
    assign count_wide = (CNT_W + 7)'(count_reg);

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_value_reg  <= rv_reg;
            rsp_found_reg  <= found_reg;
            rsp_pos_reg    <= pos_wide[bdq_pkg::POS_W-1:0];
            rsp_status_reg <= status_reg;
            rsp_count_reg  <= count_wide[bdq_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.found        = rsp_found_reg;
    assign rsp.position     = rsp_pos_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.entry_count  = rsp_count_reg;

endmodule

// File: tb/sv/tb_bounded_deque_with_search_delete.sv
// Self-checking testbench for the bounded deque with search and delete-by-value.
module tb_bounded_deque_with_search_delete;
    import bdq_pkg::*;

    localparam int CAP          = 64;
    localparam int POOL_SIZE    = 8;
    localparam int DRAIN_CYCLES = 2 * CAP + 16;
    localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     found;
        logic [POS_W-1:0]         position;
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
    } deque_result_t;

    // Shadow copy of the list; predicts one response per accepted request.
    class deque_shadow;
        logic signed [DATA_W-1:0] slots [CAP];
        int                       head;
        int                       count;
        int                       errors;
        deque_result_t            pending_results [$];

        function new();
            head   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function void take_request(logic [OPCODE_W-1:0] opc, logic signed [DATA_W-1:0] val);
            deque_result_t r;
            int            idx;
            int            k;
            bit            hit;
            r        = '0;
            r.status = ST_OK;
            hit      = 1'b0;
            case (opc)
                OP_INS_FRONT, OP_INS_BACK:
                begin
                    if (count >= CAP)
                        r.status = ST_FULL;
                    else if (opc == OP_INS_FRONT)
                    begin
                        head        = (head + CAP - 1) % CAP;
                        slots[head] = val;
                        count++;
                    end
                    else
                    begin
                        slots[(head + count) % CAP] = val;
                        count++;
                    end
                end
                OP_REM_FRONT, OP_REM_BACK:
                begin
                    if (count == 0)
                        r.status = ST_EMPTY;
                    else if (opc == OP_REM_FRONT)
                    begin
                        r.result_value = slots[head];
                        head           = (head + 1) % CAP;
                        count--;
                    end
                    else
                    begin
                        r.result_value = slots[(head + count - 1) % CAP];
                        count--;
                    end
                end
                OP_SEARCH, OP_DELETE:
                begin
                    r.status = ST_NOT_FOUND;
                    for (idx = 0; idx < count; idx++)
                    begin
                        if (slots[(head + idx) % CAP] == val)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit)
                    begin
                        r.found    = 1'b1;
                        r.position = idx[POS_W-1:0];
                        r.status   = ST_OK;
                        if (opc == OP_DELETE)
                        begin
                            // close the gap toward the front
                            for (k = idx; k + 1 < count; k++)
                                slots[(head + k) % CAP] = slots[(head + k + 1) % CAP];
                            count--;
                        end
                    end
                end
                default:
                    ;
            endcase
            r.entry_count = count[COUNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void compare_response(deque_result_t got);
            deque_result_t exp;
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.result_value !== exp.result_value)
            begin
                $error("result_value: expected %0d, got %0d", exp.result_value, got.result_value);
                errors++;
            end
            if (got.found !== exp.found)
            begin
                $error("found: expected %0d, got %0d", exp.found, got.found);
                errors++;
            end
            if (got.position !== exp.position)
            begin
                $error("position: expected %0d, got %0d", exp.position, got.position);
                errors++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.entry_count !== exp.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    bit   filling;

    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];
    deque_shadow              shadow;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search_delete #(
        .CAPACITY   (CAP),
        .VALUE_BITS (DATA_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * 500000);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        deque_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.result_value = rsp_ch.result_value;
            got.found        = rsp_ch.found;
            got.position     = rsp_ch.position;
            got.status       = status_t'(rsp_ch.status);
            got.entry_count  = rsp_ch.entry_count;
            shadow.compare_response(got);
        end
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(input logic [OPCODE_W-1:0] opc,
                                input logic signed [DATA_W-1:0] val);
        if ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= opc;
        req_ch.value  <= val;
        do @(posedge clk); while (!req_ch.ready);
        shadow.take_request(opc, val);
    endtask

    // Alternate between growing toward full and draining toward empty.
    task automatic run_random(input int n_items, input int idle, input int stall);
        int                       roll;
        logic [OPCODE_W-1:0]      opc;
        logic signed [DATA_W-1:0] val;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n_items)
        begin
            if (filling && shadow.count == CAP && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (!filling && shadow.count == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            if (roll >= 98)
                opc = roll[0] ? OP_RSVD7 : OP_RSVD6;
            else if (roll < (filling ? 70 : 15))
                opc = $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
            else if (roll < (filling ? 80 : 70))
                opc = $urandom_range(1) ? OP_REM_FRONT : OP_REM_BACK;
            else
                opc = $urandom_range(1) ? OP_SEARCH : OP_DELETE;
            // reuse a small set of values so searches and deletes hit
            if ($urandom_range(99) < 65)
                val = value_pool[$urandom_range(POOL_SIZE - 1)];
            else
                val = $urandom;
            send_request(opc, val);
        end
    endtask

    initial
    begin
        shadow        = new();
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        filling       = 1'b1;
        value_pool[0] = 32'h7FFF_FFFF;
        value_pool[1] = 32'h8000_0000;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: removes flag empty, lookups miss, reserved opcodes return OK
        send_request(OP_REM_FRONT, 32'h0000_0001);
        send_request(OP_REM_BACK, 32'h0000_0002);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_DELETE, 32'hFFFF_FFFF);
        send_request(OP_RSVD6, $urandom);
        send_request(OP_RSVD7, $urandom);
        // build: -1, min, max, 0, 0x55555555, 0xAAAAAAAA
        send_request(OP_INS_BACK, 32'h7FFF_FFFF);
        send_request(OP_INS_FRONT, 32'h8000_0000);
        send_request(OP_INS_BACK, 32'h0000_0000);
        send_request(OP_INS_FRONT, 32'hFFFF_FFFF);
        send_request(OP_INS_BACK, 32'h5555_5555);
        send_request(OP_INS_BACK, 32'hAAAA_AAAA);
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'h0001_2345);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_REM_FRONT, 32'h0000_0000);
        send_request(OP_REM_BACK, 32'h0000_0000);
        send_request(OP_RSVD7, 32'h1234_5678);
        send_request(OP_SEARCH, 32'h5555_5555);
        send_request(OP_INS_FRONT, 32'h5555_5555);
        send_request(OP_DELETE, 32'h5555_5555);
        send_request(OP_SEARCH, 32'h5555_5555);

        run_random(110, 0, 0);
        run_random(110, 85, 0);
        run_random(110, 0, 85);
        run_random(120, 35, 35);

        req_ch.valid <= 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/bdq_pkg.sv
sv/bdq_req_if.sv
sv/bdq_rsp_if.sv
sv/bdq_ram.sv
sv/bounded_deque_with_search_delete.sv
tb/sv/tb_bounded_deque_with_search_delete.sv
